/* sv/assert_macros.svh */
// assertion macros used by the datapath rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/nlme_pkg.sv */
// ----------------------------------------------------------------------------
// nlme_pkg
// types and codes shared by the nfa longest match engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nlme_pkg;

    localparam logic [2:0] OP_CLASS = 3'd0;
    localparam logic [2:0] OP_LINKS = 3'd1;
    localparam logic [2:0] OP_BEGIN = 3'd2;
    localparam logic [2:0] OP_BYTE  = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    // tokens are four bits wide
    localparam int TOKEN_CODES = 16;
    // rows of one class word
    localparam int WORD_BITS   = 64;

    typedef struct packed {
        logic [2:0]  operation;
        logic [5:0]  state_index;
        logic [1:0]  word_index;
        logic [63:0] class_word;
        logic [5:0]  edge_target;
        logic        first_link_valid;
        logic [5:0]  first_link;
        logic        second_link_valid;
        logic [5:0]  second_link;
        logic        accept_valid;
        logic [3:0]  accept_token;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic        matched;
        logic [15:0] match_length;
        logic [3:0]  token_index;
    } t_out_item;

    typedef struct packed {
        logic load_word;
        logic sweep;
        logic write_links;
        logic begin_set;
        logic byte_read;
        logic edge_step;
        logic closure;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic fixed_point;
        logic out_full;
    } t_dp_status;

endpackage

`default_nettype wire

/* sv/nlme_ram.sv */
// ----------------------------------------------------------------------------
// nlme_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/nlme_ctrl.sv */
// ----------------------------------------------------------------------------
// nlme_ctrl
// sequencer for loads, byte steps, closure and result emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlme_ctrl #(
    parameter int NFA_STATES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [2:0]           i_op,
    input  wire logic [5:0]           i_state_index,
    input  wire logic                 i_out_stall,
    output logic                      o_in_stall,
    input  wire nlme_pkg::t_dp_status i_status,
    output nlme_pkg::t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_EDGE  = 2'd2;
    localparam logic [1:0] S_CLOS  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       accept;
    logic       index_ok;

    assign index_ok   = (int'(i_state_index) < NFA_STATES);
    assign o_in_stall = (r_state != S_IDLE) ||
                        ((i_op == nlme_pkg::OP_END) && i_status.out_full && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        nlme_pkg::OP_CLASS: begin
                            if (index_ok) begin
                                o_cmd.load_word = 1'b1;
                                n_state = S_SWEEP;
                            end
                        end
                        nlme_pkg::OP_LINKS: o_cmd.write_links = index_ok;
                        nlme_pkg::OP_BEGIN: begin
                            o_cmd.begin_set = 1'b1;
                            n_state = S_CLOS;
                        end
                        nlme_pkg::OP_BYTE: begin
                            o_cmd.byte_read = 1'b1;
                            n_state = S_EDGE;
                        end
                        nlme_pkg::OP_END: o_cmd.emit = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EDGE: begin
                o_cmd.edge_step = 1'b1;
                n_state = S_CLOS;
            end
            S_CLOS: begin
                o_cmd.closure = 1'b1;
                if (i_status.fixed_point) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* sv/nlme_dp.sv */
// ----------------------------------------------------------------------------
// nlme_dp
// state tables, active set, closure and accept logic, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nlme_dp #(
    parameter int NFA_STATES  = 64,
    parameter int TOKENS      = 16,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [5:0]           i_cfg_wdata,
    input  wire nlme_pkg::t_in_item   i_item,
    input  wire nlme_pkg::t_dp_cmd    i_cmd,
    output nlme_pkg::t_dp_status      o_status,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output nlme_pkg::t_out_item       o_out_item
);

    localparam int ROWS = 4 * nlme_pkg::WORD_BITS;
    localparam int RAW  = $clog2(ROWS);

    // class memory is stored transposed: one row per byte value, one bit per state
    logic [NFA_STATES-1:0] ram_rdata, ram_wdata;
    logic [RAW-1:0]        ram_raddr, ram_waddr;
    logic                  ram_we;

    logic [5:0]  r_start;
    logic [5:0]  r_si;
    logic [1:0]  r_wi;
    logic [63:0] r_word;
    logic [6:0]  r_cnt;
    logic [5:0]  sweep_k;

    logic [5:0] r_edge [NFA_STATES];
    logic       r_v1   [NFA_STATES];
    logic [5:0] r_l1   [NFA_STATES];
    logic       r_v2   [NFA_STATES];
    logic [5:0] r_l2   [NFA_STATES];
    logic       r_av   [NFA_STATES];
    logic [3:0] r_tok  [NFA_STATES];

    logic [NFA_STATES-1:0]  r_set, n_edge_set, n_clos_set, start_set;
    logic [LENGTH_BITS-1:0] r_pos, r_best_len;
    logic [3:0]             r_best_tok, low_tok;
    logic                   r_found, any_acc, out_take;
    logic [nlme_pkg::TOKEN_CODES-1:0] tok_mask;
    nlme_pkg::t_out_item    r_out;

    assign sweep_k   = 6'(r_cnt - 7'd1);
    assign ram_raddr = i_cmd.sweep ? RAW'({r_wi, r_cnt[5:0]}) : RAW'(i_item.data_byte);
    assign ram_waddr = RAW'({r_wi, sweep_k});
    assign ram_we    = i_cmd.sweep && (r_cnt != 7'd0);

    always_comb begin
        for (int s = 0; s < NFA_STATES; s++) begin
            ram_wdata[s] = (s == int'(r_si)) ? r_word[sweep_k] : ram_rdata[s];
        end
    end

    nlme_ram #(
        .WIDTH(NFA_STATES),
        .DEPTH(ROWS)
    ) u_class_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // edge step, closure step and accept search
    always_comb begin
        n_edge_set = '0;
        n_clos_set = r_set;
        tok_mask   = '0;
        for (int s = 0; s < NFA_STATES; s++) begin
            start_set[s] = (s == int'(r_start));
            for (int t = 0; t < NFA_STATES; t++) begin
                if (r_set[s] && ram_rdata[s] && (int'(r_edge[s]) == t)) begin
                    n_edge_set[t] = 1'b1;
                end
                if (r_set[s] && ((r_v1[s] && (int'(r_l1[s]) == t)) ||
                                 (r_v2[s] && (int'(r_l2[s]) == t)))) begin
                    n_clos_set[t] = 1'b1;
                end
            end
            if (r_set[s] && r_av[s] && (int'(r_tok[s]) < TOKENS)) begin
                tok_mask[r_tok[s]] = 1'b1;
            end
        end
        any_acc = |tok_mask;
        low_tok = '0;
        for (int t = nlme_pkg::TOKEN_CODES - 1; t >= 0; t--) begin
            if (tok_mask[t]) begin
                low_tok = 4'(t);
            end
        end
    end

    assign o_status.sweep_last  = (r_cnt == 7'(nlme_pkg::WORD_BITS));
    assign o_status.fixed_point = (n_clos_set == r_set);
    assign o_status.out_full    = o_out_valid;
    assign out_take             = o_out_valid && !i_out_stall;

    // tables, load registers and result register, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_si   <= i_item.state_index;
            r_wi   <= i_item.word_index;
            r_word <= i_item.class_word;
        end
        for (int s = 0; s < NFA_STATES; s++) begin
            if (i_cmd.write_links && (int'(i_item.state_index) == s)) begin
                r_edge[s] <= i_item.edge_target;
                r_v1[s]   <= i_item.first_link_valid;
                r_l1[s]   <= i_item.first_link;
                r_v2[s]   <= i_item.second_link_valid;
                r_l2[s]   <= i_item.second_link;
                r_av[s]   <= i_item.accept_valid;
                r_tok[s]  <= i_item.accept_token;
            end
        end
        if (i_cmd.emit) begin
            r_out.matched      <= r_found;
            r_out.match_length <= r_found ? 16'(r_best_len) : '0;
            r_out.token_index  <= r_found ? r_best_tok : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_cnt       <= '0;
            r_set       <= '0;
            r_pos       <= '0;
            r_best_len  <= '0;
            r_best_tok  <= '0;
            r_found     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (i_cmd.load_word) begin
                r_cnt <= '0;
            end else if (i_cmd.sweep && !o_status.sweep_last) begin
                r_cnt <= r_cnt + 7'd1;
            end
            if (i_cmd.begin_set) begin
                r_set      <= start_set;
                r_pos      <= '0;
                r_best_len <= '0;
                r_best_tok <= '0;
                r_found    <= 1'b0;
            end else if (i_cmd.byte_read) begin
                if (r_pos != '1) begin
                    r_pos <= r_pos + LENGTH_BITS'(1);
                end
            end else if (i_cmd.edge_step) begin
                r_set <= n_edge_set;
            end else if (i_cmd.closure) begin
                r_set <= n_clos_set;
                if (o_status.fixed_point && any_acc) begin
                    r_found    <= 1'b1;
                    r_best_len <= r_pos;
                    r_best_tok <= low_tok;
                end
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (out_take) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_item = r_out;

    `ASSERT_IMPL(a_sweep_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 7'(nlme_pkg::WORD_BITS))
    `ASSERT_NEXT(a_closure_grows, i_clk, i_rst_n, i_cmd.closure, (r_set & $past(r_set)) == $past(r_set))
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.emit, !o_out_valid || !i_out_stall)

endmodule

`default_nettype wire

/* sv/nfa_longest_match_engine.sv */
// ----------------------------------------------------------------------------
// nfa_longest_match_engine
// thompson nfa matcher reporting the longest anchored match of a byte string
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_in_item  (nlme_pkg::t_in_item)
//  output   out        o_out_valid / i_out_stall o_out_item (nlme_pkg::t_out_item)
//  config   in         i_cfg_we                  i_cfg_wdata (start state)
//
//  byte item: byte read, edge step, then closure rounds until the active set stops growing
//  begin item: start set, then closure rounds; links and end items are handled in the idle state
//  class word load: a read-modify-write sweep over 64 rows of the class ram
//  synchronous active-low reset clears control state and the match state
//  any item waits while the engine is busy; an end item also waits while the previous result is still stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfa_longest_match_engine #(
    parameter int NFA_STATES  = 64,
    parameter int TOKENS      = 16,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration: start state
    input  wire logic               i_cfg_we,
    input  wire logic [5:0]         i_cfg_wdata,
    // input items
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire nlme_pkg::t_in_item i_in_item,
    // result items
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output nlme_pkg::t_out_item     o_out_item
);

    // command and status between sequencer and datapath
    nlme_pkg::t_dp_cmd    cmd;
    nlme_pkg::t_dp_status status;

    // sequencer: decodes items, runs the sweep and the closure loop
    nlme_ctrl #(
        .NFA_STATES(NFA_STATES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_op         (i_in_item.operation),
        .i_state_index(i_in_item.state_index),
        .i_out_stall  (i_out_stall),
        .o_in_stall   (o_in_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // datapath: tables, active set, best match and result register
    nlme_dp #(
        .NFA_STATES (NFA_STATES),
        .TOKENS     (TOKENS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives load, begin, byte and end items into the nfa matcher and checks each
// reported longest match against a behavioral nfa kept in the testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    // drain margin covering class word loads and closure rounds
    localparam int DRAIN_CYCLES   = 200;
    // unused operation codes
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [5:0] cfg_wdata;
    logic      in_valid;
    logic      in_stall;
    nlme_pkg::t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    nlme_pkg::t_out_item out_item;

    nfa_longest_match_engine u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // predictor state: mirror of the nfa tables and match state
    logic [63:0] nfa_class [256];
    logic [5:0]  nfa_edge [64];
    logic        nfa_v1 [64], nfa_v2 [64], nfa_acc [64];
    logic [5:0]  nfa_l1 [64], nfa_l2 [64];
    logic [3:0]  nfa_tok [64];
    logic [63:0] live_set;
    logic [15:0] pos_count, best_len;
    logic [3:0]  best_tok;
    logic        found;
    logic [5:0]  start_reg;

    nlme_pkg::t_in_item  pending_items [$];
    nlme_pkg::t_out_item expected_matches [$];

    int  error_count;
    int  sender_idle_pct, receiver_idle_pct;
    int  hold_cycles;
    bit  stimulus_done;
    int  idle_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic queue_item(input nlme_pkg::t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [63:0] eps_closure(input logic [63:0] seed);
        logic [63:0] s;
        logic [63:0] prev;
        s = seed;
        do begin
            prev = s;
            for (int k = 0; k < 64; k++) begin
                if (prev[k] && nfa_v1[k]) s[nfa_l1[k]] = 1'b1;
                if (prev[k] && nfa_v2[k]) s[nfa_l2[k]] = 1'b1;
            end
        end while (s != prev);
        return s;
    endfunction

    // lowest accepting token in the live set updates the best match
    task automatic score_position();
        bit any;
        logic [3:0] tok;
        any = 0;
        tok = '0;
        for (int k = 0; k < 64; k++) begin
            if (live_set[k] && nfa_acc[k] && (!any || nfa_tok[k] < tok)) begin
                tok = nfa_tok[k];
                any = 1;
            end
        end
        if (any) begin
            found = 1'b1;
            best_len = pos_count;
            best_tok = tok;
        end
    endtask

    task automatic predict_item(input nlme_pkg::t_in_item it);
        logic [63:0] nxt;
        nlme_pkg::t_out_item r;
        case (it.operation)
            nlme_pkg::OP_CLASS: nfa_class[{it.state_index, it.word_index}] = it.class_word;
            nlme_pkg::OP_LINKS: begin
                nfa_edge[it.state_index] = it.edge_target;
                nfa_v1[it.state_index]   = it.first_link_valid;
                nfa_l1[it.state_index]   = it.first_link;
                nfa_v2[it.state_index]   = it.second_link_valid;
                nfa_l2[it.state_index]   = it.second_link;
                nfa_acc[it.state_index]  = it.accept_valid;
                nfa_tok[it.state_index]  = it.accept_token;
            end
            nlme_pkg::OP_BEGIN: begin
                live_set = eps_closure(64'd1 << start_reg);
                pos_count = '0;
                best_len = '0;
                best_tok = '0;
                found = 1'b0;
                score_position();
            end
            nlme_pkg::OP_BYTE: begin
                nxt = '0;
                for (int k = 0; k < 64; k++) begin
                    if (live_set[k]
                        && nfa_class[{k[5:0], it.data_byte[7:6]}][it.data_byte[5:0]])
                        nxt[nfa_edge[k]] = 1'b1;
                end
                live_set = eps_closure(nxt);
                if (pos_count != 16'hffff) pos_count++;
                score_position();
            end
            nlme_pkg::OP_END: begin
                r.matched      = found;
                r.match_length = found ? best_len : '0;
                r.token_index  = found ? best_tok : '0;
                expected_matches.insert(expected_matches.size(), r);
            end
            default: ;
        endcase
    endtask

    // driver: offers items from the queue, prediction at acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) predict_item(in_item);
            if (!in_valid || !in_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each accepted result with the oldest expectation
    always @(posedge clk) begin
        nlme_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_matches.pop_front();
                    if (out_item.matched !== want.matched)
                        report_mismatch("matched", out_item.matched, want.matched);
                    if (out_item.match_length !== want.match_length)
                        report_mismatch("match_length", out_item.match_length,
                                        want.match_length);
                    if (out_item.token_index !== want.token_index)
                        report_mismatch("token_index", out_item.token_index,
                                        want.token_index);
                end
            end
            // long hold-off counted here lets the block back up
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || cfg_we || stimulus_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog timeout");
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic nlme_pkg::t_in_item blank_item(input logic [2:0] op);
        nlme_pkg::t_in_item it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(nlme_pkg::t_in_item)-1:0];
        it.operation = op;
        return it;
    endfunction

    function automatic nlme_pkg::t_in_item class_item(input int st, input int w,
                                                      input logic [63:0] v);
        nlme_pkg::t_in_item it;
        it = blank_item(nlme_pkg::OP_CLASS);
        it.state_index = 6'(st);
        it.word_index  = 2'(w);
        it.class_word  = v;
        return it;
    endfunction

    function automatic nlme_pkg::t_in_item byte_item(input logic [7:0] b);
        nlme_pkg::t_in_item it;
        it = blank_item(nlme_pkg::OP_BYTE);
        it.data_byte = b;
        return it;
    endfunction

    // load every state of a random nfa, dense or sparse classes
    task automatic load_random_nfa();
        nlme_pkg::t_in_item it;
        for (int st = 0; st < 64; st++) begin
            for (int w = 0; w < 4; w++) begin
                case ($urandom_range(3))
                    0: queue_item(class_item(st, w, '0));
                    1: queue_item(class_item(st, w, '1));
                    default: queue_item(class_item(st, w,
                        {$urandom, $urandom} & {$urandom, $urandom}));
                endcase
            end
            it = blank_item(nlme_pkg::OP_LINKS);
            it.state_index = 6'(st);
            it.first_link_valid  = ($urandom_range(3) == 0);
            it.second_link_valid = ($urandom_range(4) == 0);
            it.accept_valid      = ($urandom_range(4) == 0);
            queue_item(it);
        end
    endtask

    task automatic wait_drain();
        while (pending_items.size() > 0 || in_valid || expected_matches.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start(input logic [5:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        start_reg = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_strings(input int count);
        nlme_pkg::t_in_item it;
        int len;
        for (int n = 0; n < count; n = n + len + 2) begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(19) != 0) queue_item(blank_item(nlme_pkg::OP_BEGIN));
            for (int j = 0; j < len; j++) queue_item(byte_item(8'($urandom)));
            queue_item(blank_item(nlme_pkg::OP_END));
            if ($urandom_range(29) == 0)
                queue_item(blank_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
            if ($urandom_range(29) == 0) begin
                it = class_item($urandom_range(63), $urandom_range(3), {$urandom, $urandom});
                queue_item(it);
            end
        end
    endtask

    initial begin
        nlme_pkg::t_in_item it;
        error_count = 0;
        stimulus_done = 0;
        hold_cycles = 0;
        sender_idle_pct = 34;
        receiver_idle_pct = 84;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        live_set = '0;
        pos_count = '0;
        best_len = '0;
        best_tok = '0;
        found = 1'b0;
        start_reg = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: chain 0 -A-> 1 -(ff)-> 2, accepts on 1 and 2, eps 0->3 accepting
        write_start(6'd0);
        load_random_nfa();
        for (int w = 0; w < 4; w++) begin
            queue_item(class_item(0, w, (w == 1) ? 64'h2 : 64'h0));
            queue_item(class_item(1, w, (w == 3) ? 64'h8000_0000_0000_0000 : 64'h0));
            queue_item(class_item(2, w, '1));
            queue_item(class_item(3, w, '0));
        end
        it = blank_item(nlme_pkg::OP_LINKS); it.state_index = 6'd0; it.edge_target = 6'd1;
        it.first_link_valid = 1'b1; it.first_link = 6'd3; it.second_link_valid = 1'b0;
        it.accept_valid = 1'b0; queue_item(it);
        it = blank_item(nlme_pkg::OP_LINKS); it.state_index = 6'd1; it.edge_target = 6'd2;
        it.first_link_valid = 1'b0; it.second_link_valid = 1'b0;
        it.accept_valid = 1'b1; it.accept_token = 4'hf; queue_item(it);
        it = blank_item(nlme_pkg::OP_LINKS); it.state_index = 6'd2; it.edge_target = 6'd2;
        it.first_link_valid = 1'b1; it.first_link = 6'd63; it.second_link_valid = 1'b1;
        it.second_link = 6'd1; it.accept_valid = 1'b1; it.accept_token = 4'h3;
        queue_item(it);
        it = blank_item(nlme_pkg::OP_LINKS); it.state_index = 6'd3; it.edge_target = 6'd0;
        it.first_link_valid = 1'b0; it.second_link_valid = 1'b0;
        it.accept_valid = 1'b1; it.accept_token = 4'h0; queue_item(it);
        // end before any begin, then accept at begin and a second end
        queue_item(blank_item(nlme_pkg::OP_END));
        queue_item(blank_item(nlme_pkg::OP_BEGIN));
        queue_item(blank_item(nlme_pkg::OP_END));
        queue_item(blank_item(nlme_pkg::OP_END));
        queue_item(byte_item(8'h41));
        queue_item(byte_item(8'hff));
        queue_item(byte_item(8'h00));
        queue_item(blank_item(nlme_pkg::OP_END));
        queue_item(byte_item(8'h7f));
        queue_item(blank_item(OP_SPARE_HI));
        queue_item(blank_item(nlme_pkg::OP_END));
        wait_drain();

        // random phases through several start states, extremes included
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin sender_idle_pct = 84; receiver_idle_pct = 34; end
            if (ph == 2) begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            write_start(ph == 0 ? 6'd63 : 6'($urandom_range(63)));
            load_random_nfa();
            random_strings(100);
            if (ph == 2) hold_cycles = 3000;
            wait_drain();
            write_start(ph == 1 ? 6'd0 : 6'($urandom_range(63)));
            random_strings(100);
            wait_drain();
        end

        stimulus_done = 1;
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
